// ===== src/disjoint_set_union_by_rank_defines.svh =====
// assertion macros used by the controller of the union-find block
`ifndef DISJOINT_SET_UNION_BY_RANK_DEFINES_SVH
`define DISJOINT_SET_UNION_BY_RANK_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define DSU_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define DSU_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== src/dsu_pkg.sv =====
// types and constants of the union-find block
`default_nettype none

package dsu_pkg;

	localparam int VtxW        = 6;
	localparam int NumVertices = 1 << VtxW;
	localparam int HopW        = $clog2(NumVertices + 1);
	localparam int RankW       = 3;

	localparam logic [RankW-1:0] RankMax = '1;
	localparam logic [HopW-1:0]  HopMax  = HopW'(NumVertices);

	// one vertex entry: root flag, parent index, rank
	typedef struct packed {
		logic             is_root;
		logic [VtxW-1:0]  parent;
		logic [RankW-1:0] rank;
	} entry_t;

	localparam entry_t EntryReset = '{is_root: 1'b1, parent: '0, rank: '0};

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_A,
		S_CK_A,
		S_RD_B,
		S_CK_B,
		S_LINK,
		S_BUMP
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic rd;
		logic step;
		logic end_a;
		logic end_b;
		logic link;
		logic bump;
		logic emit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic walk_end;
		logic same_root;
		logic rank_eq;
	} status_t;

endpackage

`default_nettype wire

// ===== src/disjoint_set_union_by_rank.sv =====
// top level of the union-find block
//
// Union-find engine that takes edges one at a time and tells whether each
// edge joins two sets or closes a cycle.
// Input channel: an item (first_vertex, second_vertex) is taken at a rising
// edge where start is high and busy is low. busy stays high until the
// result has been issued.
// Result channel: done is high for exactly one cycle; merged and set_root
// are valid in that cycle. merged is 1 when two sets were joined, 0 when
// the edge closes a cycle; set_root is the root of the combined set.
// Walk: each walk step is a store read, then a check; an item walks from
// the first vertex to its root, then from the second, then links, plus a
// rank bump when equal ranks raise the surviving root's rank. Hops are at
// most log2 of the vertex count. The result strobe is registered from the
// link or bump step.
// Reset: every vertex becomes its own root with rank zero, at once, through
// per-entry written flags; no clearing pass is needed.
// The receiver cannot stall; a result is offered in one cycle only.
`default_nettype none

module disjoint_set_union_by_rank (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire [dsu_pkg::VtxW-1:0]  first_vertex,
	input  wire [dsu_pkg::VtxW-1:0]  second_vertex,
	output logic                     done,
	output logic                     merged,
	output logic [dsu_pkg::VtxW-1:0] set_root
);
	import dsu_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencing
	dsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// store and walk datapath
	dsu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.first_vertex  (first_vertex),
		.second_vertex (second_vertex),
		.cmd           (cmd),
		.st            (st),
		.done          (done),
		.merged        (merged),
		.set_root      (set_root)
	);

endmodule

`default_nettype wire

// ===== src/dsu_ctrl.sv =====
// controller state machine of the union-find block
`default_nettype none
`include "disjoint_set_union_by_rank_defines.svh"

module dsu_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  dsu_pkg::status_t st,
	output dsu_pkg::cmd_t    cmd,
	output logic             busy
);
	import dsu_pkg::*;

	state_t state_q;
	state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_nx = S_RD_A;
			end
			S_RD_A: state_nx = S_CK_A;
			S_CK_A: begin
				state_nx = st.walk_end ? S_RD_B : S_RD_A;
			end
			S_RD_B: state_nx = S_CK_B;
			S_CK_B: begin
				state_nx = st.walk_end ? S_LINK : S_RD_B;
			end
			S_LINK: begin
				state_nx = (!st.same_root && st.rank_eq) ? S_BUMP : S_IDLE;
			end
			S_BUMP: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_RD_A, S_RD_B: begin
				cmd.rd = 1'b1;
			end
			S_CK_A: begin
				cmd.end_a = st.walk_end;
				cmd.step  = !st.walk_end;
			end
			S_CK_B: begin
				cmd.end_b = st.walk_end;
				cmd.step  = !st.walk_end;
			end
			S_LINK: begin
				cmd.link = !st.same_root;
				cmd.emit = st.same_root || !st.rank_eq;
			end
			S_BUMP: begin
				cmd.bump = 1'b1;
				cmd.emit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// checks on the sequencing
	`DSU_ASSERT_NEXT(a_emit_idle, cmd.emit, state_q == S_IDLE, "emit not followed by idle")
	`DSU_ASSERT_NEXT(a_start_walk, start && !busy, state_q == S_RD_A, "accepted item did not walk")
	`DSU_ASSERT_NOW(a_link_distinct, cmd.link, !st.same_root, "link of equal roots")
	`DSU_ASSERT_NOW(a_bump_equal, cmd.bump, st.rank_eq && !st.same_root, "rank bump on unequal ranks")
	`DSU_ASSERT_NEXT(a_link_emit_once, cmd.emit, !cmd.emit, "two results for one item")

endmodule

`default_nettype wire

// ===== src/dsu_dp.sv =====
// datapath of the union-find block: vertex store, walk registers, result
`default_nettype none

module dsu_dp (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire [dsu_pkg::VtxW-1:0]    first_vertex,
	input  wire [dsu_pkg::VtxW-1:0]    second_vertex,
	input  dsu_pkg::cmd_t              cmd,
	output dsu_pkg::status_t           st,
	output logic                       done,
	output logic                       merged,
	output logic [dsu_pkg::VtxW-1:0]   set_root
);
	import dsu_pkg::*;

	entry_t             mem [NumVertices];
	logic [NumVertices-1:0] valid_q;
	entry_t             rd_q;
	logic               rd_valid_q;
	entry_t             rd_ent;

	logic [VtxW-1:0]  b_q;
	logic [VtxW-1:0]  cur_q;
	logic [HopW-1:0]  hops_q;
	logic [VtxW-1:0]  root_a_q;
	logic [VtxW-1:0]  root_b_q;
	logic [RankW-1:0] rank_a_q;
	logic [RankW-1:0] rank_b_q;

	logic             a_wins;
	logic [VtxW-1:0]  winner;
	logic [VtxW-1:0]  loser;
	logic [RankW-1:0] loser_rank;
	logic [RankW-1:0] bumped_rank;
	logic             done_q;
	logic             merged_q;
	logic [VtxW-1:0]  set_root_q;

	// never written entries read as their reset value
	assign rd_ent = rd_valid_q ? rd_q : EntryReset;

	// pick the surviving root
	assign a_wins      = rank_a_q > rank_b_q;
	assign winner      = a_wins ? root_a_q : root_b_q;
	assign loser       = a_wins ? root_b_q : root_a_q;
	assign loser_rank  = a_wins ? rank_b_q : rank_a_q;
	assign bumped_rank = (rank_b_q == RankMax) ? rank_b_q : rank_b_q + RankW'(1);

	// status to the controller
	assign st.walk_end  = rd_ent.is_root || (hops_q == HopMax);
	assign st.same_root = root_a_q == root_b_q;
	assign st.rank_eq   = rank_a_q == rank_b_q;

	// vertex store, registered read
	always_ff @(posedge clk) begin
		if (cmd.link) begin
			mem[loser] <= '{is_root: 1'b0, parent: winner, rank: loser_rank};
		end else if (cmd.bump) begin
			mem[root_b_q] <= '{is_root: 1'b1, parent: '0, rank: bumped_rank};
		end
		if (cmd.rd) begin
			rd_q <= mem[cur_q];
		end
	end

	// written flags of the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.link) begin
				valid_q[loser] <= 1'b1;
			end else if (cmd.bump) begin
				valid_q[root_b_q] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_valid_q <= valid_q[cur_q];
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q  <= first_vertex;
			b_q    <= second_vertex;
			hops_q <= '0;
		end else if (cmd.step) begin
			cur_q  <= rd_ent.parent;
			hops_q <= hops_q + HopW'(1);
		end else if (cmd.end_a) begin
			root_a_q <= cur_q;
			rank_a_q <= rd_ent.rank;
			cur_q    <= b_q;
			hops_q   <= '0;
		end else if (cmd.end_b) begin
			root_b_q <= cur_q;
			rank_b_q <= rd_ent.rank;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			merged_q   <= !st.same_root;
			set_root_q <= st.same_root ? root_a_q : winner;
		end
	end

	assign done     = done_q;
	assign merged   = merged_q;
	assign set_root = set_root_q;

endmodule

`default_nettype wire

// ===== tb/disjoint_set_union_by_rank_tb.sv =====
// testbench of the union-find block: directed and random edges against a rank-based predictor
`timescale 1ns / 100ps

module disjoint_set_union_by_rank_tb;
	import dsu_pkg::*;

	localparam int StallLimit   = 1000;
	localparam int SettleCycles = 40;
	localparam int RandomEdges  = 600;
	localparam int ReportMax    = 10;

	// what one edge should produce
	typedef struct packed {
		logic            merged;
		logic [VtxW-1:0] root;
	} outcome_t;

	// forest predictor plus the queue of outcomes still owed by the block
	class dsu_scoreboard;
		logic             is_top   [NumVertices];
		logic [VtxW-1:0]  up_link  [NumVertices];
		logic [RankW-1:0] rank_tbl [NumVertices];
		outcome_t         owed_q[$];
		int               mismatches;

		function new();
			foreach (is_top[v]) begin
				is_top[v]   = 1'b1;
				up_link[v]  = '0;
				rank_tbl[v] = '0;
			end
			mismatches = 0;
		endfunction

		// follow parent links, bounded by the vertex count
		function logic [VtxW-1:0] top_of(input logic [VtxW-1:0] v);
			logic [VtxW-1:0] cur;
			cur = v;
			for (int hop = 0; hop < NumVertices; hop++) begin
				if (is_top[cur])
					break;
				cur = up_link[cur];
			end
			return cur;
		endfunction

		// apply one accepted edge and queue its outcome
		function void note_edge(input logic [VtxW-1:0] a, input logic [VtxW-1:0] b);
			logic [VtxW-1:0] ra;
			logic [VtxW-1:0] rb;
			logic [VtxW-1:0] top;
			ra = top_of(a);
			rb = top_of(b);
			if (ra == rb) begin
				owed_q.push_back('{merged: 1'b0, root: ra});
				return;
			end
			if (rank_tbl[ra] > rank_tbl[rb]) begin
				is_top[rb]  = 1'b0;
				up_link[rb] = ra;
				top         = ra;
			end else begin
				// lower or equal rank: first root goes under the second
				is_top[ra]  = 1'b0;
				up_link[ra] = rb;
				top         = rb;
				if (rank_tbl[ra] == rank_tbl[rb] && rank_tbl[rb] != RankMax)
					rank_tbl[rb] = rank_tbl[rb] + 1'b1;
			end
			owed_q.push_back('{merged: 1'b1, root: top});
		endfunction

		// compare one result against the oldest owed outcome
		function void check_result(input logic got_merged, input logic [VtxW-1:0] got_root);
			outcome_t want;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportMax)
					$display("unexpected result: merged=%0b set_root=%0d", got_merged, got_root);
				return;
			end
			want = owed_q.pop_front();
			if (got_merged !== want.merged || got_root !== want.root) begin
				mismatches++;
				if (mismatches <= ReportMax)
					$display("result mismatch: merged exp %0b got %0b, set_root exp %0d got %0d",
						want.merged, got_merged, want.root, got_root);
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic [VtxW-1:0] first_vertex = '0;
	logic [VtxW-1:0] second_vertex = '0;
	logic            busy;
	logic            done;
	logic            merged;
	logic [VtxW-1:0] set_root;

	dsu_scoreboard sb;
	int            stall_cycles = 0;

	disjoint_set_union_by_rank i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.first_vertex (first_vertex),
		.second_vertex(second_vertex),
		.done         (done),
		.merged       (merged),
		.set_root     (set_root)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// results and watchdog, sampled mid-cycle where everything is settled
	always @(negedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(merged, set_root);
			if (done || (start && !busy)) begin
				stall_cycles = 0;
			end else if (stall_cycles >= StallLimit) begin
				$display("FAILURE");
				$finish;
			end else begin
				stall_cycles = stall_cycles + 1;
			end
		end
	end

	// offer one item and hold it until the block takes it
	task automatic send_edge(input logic [VtxW-1:0] a, input logic [VtxW-1:0] b);
		start         <= 1'b1;
		first_vertex  <= a;
		second_vertex <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_edge(a, b);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every owed result has come back
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// mostly edges across sets (equal ranks preferred), some within a set, some uniform
	task automatic pick_edge(output logic [VtxW-1:0] a, output logic [VtxW-1:0] b);
		int              mode;
		logic [VtxW-1:0] ra;
		logic [VtxW-1:0] rb;
		mode = $urandom_range(0, 9);
		a = VtxW'($urandom_range(0, NumVertices - 1));
		b = VtxW'($urandom_range(0, NumVertices - 1));
		if (mode < 8) begin
			for (int tries = 0; tries < 24; tries++) begin
				ra = sb.top_of(a);
				rb = sb.top_of(b);
				if (mode < 6 && ra != rb
					&& (sb.rank_tbl[ra] == sb.rank_tbl[rb] || tries >= 12))
					break;
				if (mode >= 6 && ra == rb && a != b)
					break;
				a = VtxW'($urandom_range(0, NumVertices - 1));
				b = VtxW'($urandom_range(0, NumVertices - 1));
			end
		end
	endtask

	initial begin : stimulus
		logic [VtxW-1:0] a;
		logic [VtxW-1:0] b;
		int              burst_left;
		int              gap;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// self edges at both ends of the index range
		send_edge(6'd0, 6'd0);
		send_edge(6'd63, 6'd63);
		// equal ranks, then the cycle it closes
		send_edge(6'd0, 6'd63);
		send_edge(6'd63, 6'd0);
		pause(3);
		send_edge(6'd1, 6'd2);
		send_edge(6'd0, 6'd1);
		// second root higher, then first root higher
		send_edge(6'd3, 6'd0);
		send_edge(6'd1, 6'd4);
		send_edge(6'd63, 6'd3);
		drain();
		// alternating bit patterns
		send_edge(6'd42, 6'd21);
		send_edge(6'd21, 6'd42);
		send_edge(6'd21, 6'd4);
		send_edge(6'd42, 6'd42);
		pause(1);
		send_edge(6'd62, 6'd61);
		send_edge(6'd60, 6'd59);
		send_edge(6'd62, 6'd60);
		send_edge(6'd63, 6'd59);
		send_edge(6'd0, 6'd61);
		drain();

		// random edges in bursts
		burst_left = $urandom_range(1, 16);
		for (int n = 0; n < RandomEdges; n++) begin
			pick_edge(a, b);
			send_edge(a, b);
			if (n % 150 == 149) begin
				drain();
			end else begin
				burst_left = burst_left - 1;
				if (burst_left == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 10);
					pause(gap);
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
						: $urandom_range(1, 16);
				end
			end
		end

		drain();
		repeat (SettleCycles) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
